### rtl/core/salc_pkg.sv
// shared types and codes of the size-aware lru cache
package salc_pkg;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_HIT     = 2'd0,
        OUT_LOADED  = 2'd1,
        OUT_TOO_BIG = 2'd2,
        OUT_EVICTED = 2'd3
    } t_outcome;

    localparam logic [31:0] BUDGET_RESET = 32'd16777216;

endpackage

### rtl/core/salc_ram.sv
// generic single-port-write ram with registered read
module salc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/size_aware_lru_cache.sv
// size-aware lru cache with byte budget, top level
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (byte budget)
//  request | in        | i_in_valid / o_in_stall   | i_resource_key, i_resource_size
//  result  | out       | o_out_valid / i_out_stall | o_outcome, o_reported_key,
//          |           |                           | o_bytes_in_use, o_last_of_run
//
// a request's key lookup is a sequential scan over the key ram.
// a miss adds an lru rank scan plus ram read per evicted entry and a scan to find a free slot
// and insert; a hit or a failed request then only emits its result.
// reset clears valid bits, ranks and byte count and reloads the budget; key and size rams need no pass.
// a stalled result holds the sequencer in its emit state; the next request is taken while the
// last result of the previous one still waits in the output register.
module size_aware_lru_cache
    import salc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration transaction
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // request transaction
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_resource_key,
    input  logic [31:0] i_resource_size,
    // result transaction
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_reported_key,
    output logic [31:0] o_bytes_in_use,
    output logic        o_last_of_run
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MISS,
        ST_HIT,
        ST_FAIL,
        ST_EV_CHK,
        ST_EV_SCAN,
        ST_EV_OUT,
        ST_INS_SCAN,
        ST_INS_OUT
    } t_state;

    t_state          r_state;
    logic [31:0]     r_budget;
    logic [31:0]     r_alloc;
    logic [CW-1:0]   r_count;
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]   r_rank [ENTRIES];
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_chk_idx;
    logic            r_chk_vld;
    logic [31:0]     r_key;
    logic [31:0]     r_size;

    logic            r_out_valid;
    logic [1:0]      r_outcome;
    logic [31:0]     r_rep_key;
    logic [31:0]     r_bytes;
    logic            r_last;

    logic [31:0]     key_rdata;
    logic [31:0]     size_rdata;
    logic            out_free;
    logic            emit;
    logic            ram_we;
    logic            need_room;
    logic [IW-1:0]   hit_rank;
    logic [IW-1:0]   lru_rank;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit      = out_free && ((r_state == ST_HIT) || (r_state == ST_FAIL)
                                    || (r_state == ST_EV_OUT) || (r_state == ST_INS_OUT));
    assign ram_we    = (r_state == ST_INS_OUT) && out_free;
    assign need_room = ({1'b0, r_alloc} + {1'b0, r_size} > {1'b0, r_budget})
                       || (r_count == FULL_CNT);
    assign hit_rank  = r_rank[r_idx];
    assign lru_rank  = IW'(r_count - CW'(1));

    // key and size stores
    salc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_raddr (r_idx),
        .o_rdata (key_rdata)
    );

    salc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_size),
        .i_raddr (r_idx),
        .o_rdata (size_rdata)
    );

    // sequencer, store bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_budget    <= BUDGET_RESET;
            r_alloc     <= '0;
            r_count     <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_chk_idx   <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            // configuration write
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end

            // result register loads on emit and drains downstream
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_key     <= i_resource_key;
                        r_size    <= i_resource_size;
                        r_idx     <= '0;
                        r_chk_vld <= 1'b0;
                        r_state   <= ST_LOOKUP;
                    end
                end

                // key compare trails the ram address through the registered read
                ST_LOOKUP: begin
                    if (r_chk_vld && r_valid[r_chk_idx] && key_rdata == r_key) begin
                        r_idx   <= r_chk_idx;
                        r_state <= ST_HIT;
                    end else if (r_chk_vld && r_chk_idx == LAST_IDX) begin
                        r_state <= ST_MISS;
                    end else begin
                        r_chk_vld <= 1'b1;
                        r_chk_idx <= r_idx;
                        if (r_idx != LAST_IDX) begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end

                ST_MISS: begin
                    if (r_size > r_budget) begin
                        r_state <= ST_FAIL;
                    end else begin
                        r_state <= ST_EV_CHK;
                    end
                end

                // hit: move to most recent
                ST_HIT: begin
                    if (out_free) begin
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j] && r_rank[j] < hit_rank) begin
                                r_rank[j] <= r_rank[j] + IW'(1);
                            end
                        end
                        r_rank[r_idx] <= '0;
                        r_outcome     <= OUT_HIT;
                        r_rep_key     <= r_key;
                        r_bytes       <= r_alloc;
                        r_last        <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end

                ST_FAIL: begin
                    if (out_free) begin
                        r_outcome   <= OUT_TOO_BIG;
                        r_rep_key   <= r_key;
                        r_bytes     <= r_alloc;
                        r_last      <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end

                // decide whether another victim is needed
                ST_EV_CHK: begin
                    r_idx <= '0;
                    if (need_room && r_count != '0) begin
                        r_state <= ST_EV_SCAN;
                    end else begin
                        r_state <= ST_INS_SCAN;
                    end
                end

                // look for the entry holding the largest rank
                ST_EV_SCAN: begin
                    if (r_valid[r_idx] && r_rank[r_idx] == lru_rank) begin
                        r_state <= ST_EV_OUT;
                    end else if (r_idx == LAST_IDX) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                ST_EV_OUT: begin
                    if (out_free) begin
                        r_valid[r_idx] <= 1'b0;
                        r_alloc        <= r_alloc - size_rdata;
                        r_count        <= r_count - CW'(1);
                        r_outcome      <= OUT_EVICTED;
                        r_rep_key      <= key_rdata;
                        r_bytes        <= r_alloc - size_rdata;
                        r_last         <= 1'b0;
                        r_state        <= ST_EV_CHK;
                    end
                end

                // first free slot
                ST_INS_SCAN: begin
                    if (!r_valid[r_idx]) begin
                        r_state <= ST_INS_OUT;
                    end else if (r_idx == LAST_IDX) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                // insert as most recent
                ST_INS_OUT: begin
                    if (out_free) begin
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j]) begin
                                r_rank[j] <= r_rank[j] + IW'(1);
                            end
                        end
                        r_rank[r_idx]  <= '0;
                        r_valid[r_idx] <= 1'b1;
                        r_count        <= r_count + CW'(1);
                        r_alloc        <= r_alloc + r_size;
                        r_outcome      <= OUT_LOADED;
                        r_rep_key      <= r_key;
                        r_bytes        <= r_alloc + r_size;
                        r_last         <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_reported_key = r_rep_key;
    assign o_bytes_in_use = r_bytes;
    assign o_last_of_run  = r_last;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the size-aware lru cache with byte budget
module testbench;
    import salc_pkg::*;

    localparam int SLOTS = 16;
    localparam int POOL_KEYS = 24;
    localparam int PHASE_ITEMS = 48;
    localparam int SETTLE_CYCLES = 4 * (SLOTS + 2);
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT = 21;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] size;
    } t_request;

    typedef struct packed {
        t_outcome    outcome;
        logic [31:0] key;
        logic [31:0] bytes;
        logic        last;
    } t_result;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_resource_key = '0;
    logic [31:0] i_resource_size = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_outcome;
    logic [31:0] o_reported_key;
    logic [31:0] o_bytes_in_use;
    logic        o_last_of_run;

    // cache contents as the bench sees them
    logic [31:0] slot_key [SLOTS];
    logic [31:0] slot_size [SLOTS];
    logic        slot_used [SLOTS];
    int unsigned slot_rank [SLOTS];
    logic [31:0] held_bytes = '0;
    logic [31:0] budget = BUDGET_RESET;

    t_request    request_q [$];
    t_result     predicted_q [$];
    logic [31:0] key_pool [POOL_KEYS];

    logic        took_request = 1'b0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_budgets = 1;
    int          errors = 0;
    int          seen_outcome [4] = '{0, 0, 0, 0};
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    size_aware_lru_cache #(.ENTRIES(SLOTS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_resource_key  (i_resource_key),
        .i_resource_size (i_resource_size),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_outcome       (o_outcome),
        .o_reported_key  (o_reported_key),
        .o_bytes_in_use  (o_bytes_in_use),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // window with no idling on either side
    function automatic logic calm_stretch();
        return n_accepted >= 120 && n_accepted < 180;
    endfunction

    task automatic expect_result(input t_outcome outcome, input logic [31:0] key,
                                 input logic last);
        t_result r;
        r.outcome = outcome;
        r.key = key;
        r.bytes = held_bytes;
        r.last = last;
        predicted_q.push_back(r);
    endtask

    // apply one request to the cache image and queue the results it causes
    task automatic cache_access(input logic [31:0] key, input logic [31:0] size);
        int   hit_slot;
        int   lru;
        int   free_slot;
        logic full;
        logic [63:0] need;
        hit_slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key) hit_slot = i;
        // hit: promote to most recent, stored size kept
        if (hit_slot >= 0) begin
            for (int j = 0; j < SLOTS; j++)
                if (slot_used[j] && slot_rank[j] < slot_rank[hit_slot]) slot_rank[j]++;
            slot_rank[hit_slot] = 0;
            expect_result(OUT_HIT, key, 1'b1);
            return;
        end
        if (size > budget) begin
            expect_result(OUT_TOO_BIG, key, 1'b1);
            return;
        end
        // evict lru entries until the size fits and a slot is free
        forever begin
            full = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                if (!slot_used[i]) full = 1'b0;
            need = 64'(held_bytes) + 64'(size);
            if (need <= 64'(budget) && !full) break;
            lru = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && (lru < 0 || slot_rank[i] > slot_rank[lru])) lru = i;
            if (lru < 0) break;
            slot_used[lru] = 1'b0;
            held_bytes = held_bytes - slot_size[lru];
            expect_result(OUT_EVICTED, slot_key[lru], 1'b0);
        end
        // insert as most recent
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && free_slot < 0) free_slot = i;
        if (free_slot >= 0) begin
            for (int j = 0; j < SLOTS; j++)
                if (slot_used[j]) slot_rank[j]++;
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_size[free_slot] = size;
            slot_rank[free_slot] = 0;
            held_bytes = held_bytes + size;
        end
        expect_result(OUT_LOADED, key, 1'b1);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result checking and request acceptance
    always @(posedge i_clk) begin
        t_result want;
        took_request <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            seen_outcome[o_outcome]++;
            if (predicted_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual outcome %0d key %h",
                         $time, o_outcome, o_reported_key);
            end else begin
                want = predicted_q.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(o_outcome));
                check_field("reported_key", want.key, o_reported_key);
                check_field("bytes_in_use", want.bytes, o_bytes_in_use);
                check_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            void'(request_q.pop_front());
            n_accepted++;
            cache_access(i_resource_key, i_resource_size);
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || took_request) begin
            if (request_q.size() != 0
                && (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_resource_key <= request_q[0].key;
                i_resource_size <= request_q[0].size;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (!hold_done && n_results >= 30) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm_stretch() && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic t_request random_request();
        t_request    req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        req.key = (pick < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)] : $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 70)      req.size = $urandom_range(0, budget / 5);
        else if (pick < 78) req.size = '0;
        else if (pick < 86) req.size = $urandom();
        else if (pick < 93) req.size = budget;
        else                req.size = budget + 1;
        return req;
    endfunction

    task automatic add_request(input logic [31:0] key, input logic [31:0] size);
        t_request req;
        req.key = key;
        req.size = size;
        request_q.push_back(req);
    endtask

    task automatic add_random_phase();
        repeat (PHASE_ITEMS) request_q.push_back(random_request());
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || predicted_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_budget(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        budget = value;
        n_budgets++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        logic [31:0] budgets [6];
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_rank[i] = 0;
        end
        for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        budgets = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd300, BUDGET_RESET,
                    32'($urandom_range(64, 100000))};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero size, hit with other size, exact fit, too large,
        // eviction for bytes, filling every slot, then a late hit
        add_request(32'd0, 32'd0);
        add_request(32'd0, 32'd100);
        add_request(32'hFFFF_FFFF, BUDGET_RESET);
        add_request(32'd1, BUDGET_RESET + 1);
        add_request(32'd2, 32'd1);
        add_request(32'hFFFF_FFFF, 32'd5);
        for (int i = 0; i <= SLOTS; i++) add_request(32'h100 + i, 32'(i));
        add_request(32'h10A, 32'd7);
        add_request(32'hA5A5_5A5A, 32'h5A5A_A5A5);
        add_random_phase();
        wait_idle();

        // budget sweep, including a drop below the bytes held
        foreach (budgets[p]) begin
            write_budget(budgets[p]);
            add_random_phase();
            wait_idle();
        end

        $display("covered %0d requests over %0d budget settings, %0d results checked",
                 n_accepted, n_budgets, n_results);
        $display("outcomes seen: %0d hits, %0d loads, %0d too large, %0d evictions",
                 seen_outcome[OUT_HIT], seen_outcome[OUT_LOADED],
                 seen_outcome[OUT_TOO_BIG], seen_outcome[OUT_EVICTED]);
        if (errors == 0 && predicted_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("timeout with %0d results still due", predicted_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
